/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion wrappers
// clocked on clk_i, with and without the active-low reset rst_ni
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define GH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define GH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/ghash_pkg.sv */
// ----------------------------------------------------------------------------
// ghash_pkg
// widths, register indexes, command type and gf(2^128) helper functions
// ----------------------------------------------------------------------------
`default_nettype none

package ghash_pkg;

  localparam int unsigned HalfW    = 64;
  localparam int unsigned BlockW   = 2 * HalfW;
  localparam int unsigned NbW      = 5;
  localparam int unsigned NumBytes = BlockW / 8;
  localparam int unsigned StepBits = 8;
  localparam int unsigned NumSteps = BlockW / StepBits;
  localparam int unsigned CntW     = $clog2(NumSteps);
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned InDataW  = ((2 * HalfW + NbW + 7) / 8) * 8;

  localparam logic [7:0] RTop = 8'hE1;

  localparam logic [CfgIdxW-1:0] CFG_H_HIGH = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_H_LOW  = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic commit_step;
    logic commit_hold;
  } ghash_cmd_t;

  typedef struct packed {
    logic [BlockW-1:0] r;
    logic [BlockW-1:0] v;
  } ghash_rv_t;

  // eight bits of the shift-and-add multiply, msb of xb first
  function automatic ghash_rv_t ghash_mul8(input logic [BlockW-1:0] r,
                                           input logic [BlockW-1:0] v,
                                           input logic [StepBits-1:0] xb);
    ghash_rv_t         res;
    logic [BlockW-1:0] rr;
    logic [BlockW-1:0] vv;
    logic              c;
    rr = r;
    vv = v;
    for (int i = StepBits - 1; i >= 0; i--) begin
      if (xb[i]) rr = rr ^ vv;
      c  = vv[0];
      vv = vv >> 1;
      if (c) vv[BlockW-1 -: 8] = vv[BlockW-1 -: 8] ^ RTop;
    end
    res.r = rr;
    res.v = vv;
    return res;
  endfunction

  // keep the leading nb bytes, byte 0 in the top bits
  function automatic logic [BlockW-1:0] ghash_byte_mask(input logic [NbW-1:0] nb);
    logic [BlockW-1:0] m;
    m = '0;
    for (int k = 0; k < NumBytes; k++) begin
      m[BlockW-1-8*k -: 8] = {8{nb > NbW'(k)}};
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/ghash_ctrl.sv */
// ----------------------------------------------------------------------------
// ghash_ctrl
// sequencer: accepts a beat, runs sixteen multiply steps, hands over the result
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ghash_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_tvalid_i,
  output logic                  s_tready_o,
  output logic                  m_tvalid_o,
  input  wire                   m_tready_i,
  output ghash_pkg::ghash_cmd_t cmd_o
);
  import ghash_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_HOLD
  } state_e;

  localparam logic [CntW-1:0] CntLast = CntW'(NumSteps - 1);

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            out_valid_q;
  logic            slot_free;
  logic            commit;

  assign slot_free  = !out_valid_q || m_tready_i;
  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = out_valid_q;
  assign commit     = cmd_o.commit_step || cmd_o.commit_hold;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = s_tvalid_i;
      end
      ST_MUL: begin
        cmd_o.step        = 1'b1;
        cmd_o.commit_step = (cnt_q == CntLast) && slot_free;
      end
      ST_HOLD: begin
        cmd_o.commit_hold = slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (s_tvalid_i) state_q <= ST_MUL;
        end
        ST_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntLast) begin
            state_q <= slot_free ? ST_IDLE : ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (slot_free) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `GH_ASSERT(a_commit_slot_free, commit |-> slot_free, "result committed over a pending beat")
  `GH_ASSERT(a_accept_starts_mul, (s_tvalid_i && s_tready_o) |=> (state_q == ST_MUL && cnt_q == '0), "accepted beat did not start the multiply")
  `GH_ASSERT(a_mul_ends, (state_q == ST_MUL && cnt_q == CntLast) |=> (state_q == ST_IDLE || state_q == ST_HOLD), "multiply ran past its last step")
  `GH_ASSERT(a_valid_after_commit, $rose(out_valid_q) |-> $past(commit), "output valid without a commit")
  `GH_ASSERT_ALWAYS(a_cmd_exclusive, $onehot0({cmd_o.load, cmd_o.commit_step, cmd_o.commit_hold}), "conflicting datapath commands")

endmodule

`default_nettype wire

/* rtl/ghash_dp.sv */
// ----------------------------------------------------------------------------
// ghash_dp
// key registers, accumulator and the eight-bit-per-cycle gf(2^128) multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module ghash_dp (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  ghash_pkg::ghash_cmd_t               cmd_i,
  input  wire                                 cfg_we_i,
  input  wire  [ghash_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire  [ghash_pkg::HalfW-1:0]         cfg_data_i,
  input  wire                                 first_i,
  input  wire  [ghash_pkg::BlockW-1:0]        block_i,
  input  wire  [ghash_pkg::NbW-1:0]           valid_bytes_i,
  output logic [ghash_pkg::BlockW-1:0]        hash_o
);
  import ghash_pkg::*;

  logic [HalfW-1:0]  h_high_q;
  logic [HalfW-1:0]  h_low_q;
  logic [BlockW-1:0] acc_q;
  logic [BlockW-1:0] x_q;
  logic [BlockW-1:0] r_q;
  logic [BlockW-1:0] v_q;
  logic [BlockW-1:0] x_load;
  ghash_rv_t         step_res;

  assign x_load   = (first_i ? '0 : acc_q) ^ (block_i & ghash_byte_mask(valid_bytes_i));
  assign step_res = ghash_mul8(r_q, v_q, x_q[BlockW-1 -: StepBits]);
  assign hash_o   = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_high_q <= '0;
      h_low_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_H_HIGH: h_high_q <= cfg_data_i;
        CFG_H_LOW:  h_low_q  <= cfg_data_i;
        default:    h_high_q <= h_high_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.commit_step) begin
      acc_q <= step_res.r;
    end else if (cmd_i.commit_hold) begin
      acc_q <= r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= x_load;
      r_q <= '0;
      v_q <= {h_high_q, h_low_q};
    end else if (cmd_i.step) begin
      x_q <= x_q << StepBits;
      r_q <= step_res.r;
      v_q <= step_res.v;
    end
  end

endmodule

`default_nettype wire

/* rtl/ghash_accumulator_unit.sv */
// ----------------------------------------------------------------------------
// ghash_accumulator_unit
// gcm ghash: y = (y xor x) * h in gf(2^128), one 128-bit block per beat
// ----------------------------------------------------------------------------
// channel   direction  contents
// s_axis    in         tdata block and byte count, tuser first flag
// m_axis    out        tdata updated hash
// cfg       in         write of hash key halves h_high, h_low
//
// the accepting edge loads the multiplier, then sixteen steps follow at eight
// key-shift bits per cycle; the hash beat is valid once the result is committed.
// s_axis_tready is high only while no block is in the multiplier, so a new
// block is not taken before the previous one has left the multiplier.
// a finished block whose previous hash beat still waits on m_axis_tready is
// held with s_axis_tready low until that beat leaves.
// reset clears the key and the accumulator; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ghash_accumulator_unit (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [ghash_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire  [ghash_pkg::HalfW-1:0]         cfg_data_i,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // block_high, block_low, valid_bytes, zero fill
  input  wire  [ghash_pkg::InDataW-1:0]       s_axis_tdata,
  // first
  input  wire  [0:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // hash_high, hash_low
  output logic [ghash_pkg::BlockW-1:0]        m_axis_tdata
);
  import ghash_pkg::*;

  ghash_cmd_t        cmd;
  logic [BlockW-1:0] block;
  logic [BlockW-1:0] hash;

  assign block        = {s_axis_tdata[HalfW-1:0], s_axis_tdata[2*HalfW-1:HalfW]};
  assign m_axis_tdata = {hash[HalfW-1:0], hash[BlockW-1:HalfW]};

  ghash_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd)
  );

  ghash_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .first_i       (s_axis_tuser[0]),
    .block_i       (block),
    .valid_bytes_i (s_axis_tdata[2*HalfW+NbW-1:2*HalfW]),
    .hash_o        (hash)
  );

endmodule

`default_nettype wire
